### design/vec3_pkg.sv
// vec3_pkg: shared command codes, control struct and default widths
// for the three-component vector unit. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vec3_pkg;

  localparam int CMD_W         = 3;
  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;

  typedef logic [CMD_W-1:0] cmd_t;

  localparam cmd_t CMD_ADD   = 3'd0;
  localparam cmd_t CMD_SUB   = 3'd1;
  localparam cmd_t CMD_CROSS = 3'd2;
  localparam cmd_t CMD_DOT   = 3'd3;
  localparam cmd_t CMD_LSQ   = 3'd4;
  localparam cmd_t CMD_LEN   = 3'd5;
  localparam cmd_t CMD_NORM  = 3'd6;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } ctl_t;

endpackage

`default_nettype wire

### design/vector3_alu.sv
// vector3_alu: top level, three lanes, dot/length merge, square root and
// divider pipelines, output select. Depends on vec3_pkg and the vec3_* units.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-----------------------------------------
//   input    | in_valid / in_stall | command, ax, ay, az, bx, by, bz
//   output   | out_valid/out_stall | rx, ry, rz, scalar, overflow, zero_length
//
// one item per clock while a held output does not stall the pipeline; default format Q16.16
// every item passes through the square root (one stage per root bit) followed by the
// divider (one stage per quotient bit); every command takes the same path
// a held output stalls the whole pipeline, in_stall follows it in the same cycle
// synchronous reset clears the valid bits only; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module vector3_alu #(
  parameter int WORD_BITS = vec3_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = vec3_pkg::FRAC_BITS_DEF
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         in_valid,
  output logic                        in_stall,
  input  wire vec3_pkg::cmd_t         command,
  input  wire signed [WORD_BITS-1:0]  ax,
  input  wire signed [WORD_BITS-1:0]  ay,
  input  wire signed [WORD_BITS-1:0]  az,
  input  wire signed [WORD_BITS-1:0]  bx,
  input  wire signed [WORD_BITS-1:0]  by,
  input  wire signed [WORD_BITS-1:0]  bz,
  output logic                        out_valid,
  input  wire                         out_stall,
  output logic signed [WORD_BITS-1:0] rx,
  output logic signed [WORD_BITS-1:0] ry,
  output logic signed [WORD_BITS-1:0] rz,
  output logic signed [WORD_BITS-1:0] scalar,
  output logic                        overflow,
  output logic                        zero_length
);
  import vec3_pkg::*;

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int PW  = 2 * W;
  localparam int DW  = PW + 2 - F;
  localparam int QSW = PW - F;
  localparam int QW  = W + F + 2;
  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
  localparam logic [F:0] QMAX = (F+1)'(1) << F;

  typedef struct packed {
    logic              valid;
    cmd_t              cmd;
    logic [2:0][W-1:0] vec;
    logic              vec_ovf;
    logic [W-1:0]      dot;
    logic              dot_ovf;
    logic [W-1:0]      sq;
    logic              sq_ovf;
    logic [W-1:0]      len;
    logic              len_ovf;
    logic              s_zero;
    logic [2:0][W-1:0] a_mag;
    logic [2:0]        a_neg;
  } side_t;

  logic ce;
  ctl_t ctl1, ctl2;

  logic signed [W-1:0]  a_in [3];
  logic signed [W-1:0]  b_in [3];
  logic signed [W-1:0]  l_vec [3];
  logic [2:0]           l_ovf;
  logic signed [PW-1:0] l_paa [3];
  logic signed [PW-1:0] l_pab [3];
  logic [W-1:0]         l_mag [3];
  logic [2:0]           l_neg;

  logic [PW-1:0]        s_sum;
  logic signed [PW+1:0] d_sum;
  logic signed [DW-1:0] dot_sh;
  logic [QSW-1:0]       sq_sh;
  side_t                side_in, side_mid;

  side_t side_a [W];
  side_t side_b [F+1];
  side_t last;

  logic [W-1:0] root;
  logic [F:0]   quo [3];

  logic signed [QW-1:0] q_sgn [3];
  logic [2:0][W-1:0]    nq;
  logic [2:0]           nq_ovf;

  logic [2:0][W-1:0] vec_next, out_vec;
  logic [W-1:0]      scalar_next;
  logic              ovf_next, zl_next;

  assign ce       = !(out_valid && out_stall);
  assign in_stall = !ce;

  assign a_in[0] = ax;
  assign a_in[1] = ay;
  assign a_in[2] = az;
  assign b_in[0] = bx;
  assign b_in[1] = by;
  assign b_in[2] = bz;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    vec3_lane #(.W(W), .F(F)) u_lane (
      .clk     (clk),
      .ce      (ce),
      .cmd     (command),
      .a_self  (a_in[i]),
      .b_self  (b_in[i]),
      .a_next  (a_in[(i + 1) % 3]),
      .b_next  (b_in[(i + 1) % 3]),
      .a_far   (a_in[(i + 2) % 3]),
      .b_far   (b_in[(i + 2) % 3]),
      .vec     (l_vec[i]),
      .vec_ovf (l_ovf[i]),
      .p_aa    (l_paa[i]),
      .p_ab    (l_pab[i]),
      .a_mag   (l_mag[i]),
      .a_neg   (l_neg[i])
    );

    vec3_div #(.W(W), .F(F)) u_div (
      .clk (clk),
      .ce  (ce),
      .mag (side_a[W-1].a_mag[i]),
      .den (root),
      .quo (quo[i])
    );
  end

  // merge: squared length and dot product over the three lanes
  always_comb begin
    s_sum  = $unsigned(l_paa[0]) + $unsigned(l_paa[1]) + $unsigned(l_paa[2]);
    d_sum  = (PW+2)'(l_pab[0]) + (PW+2)'(l_pab[1]) + (PW+2)'(l_pab[2]);
    dot_sh = DW'(d_sum >>> F);
    sq_sh  = QSW'(s_sum >> F);

    side_in = '0;
    side_in.valid   = ctl2.valid;
    side_in.cmd     = ctl2.cmd;
    for (int i = 0; i < 3; i++) begin
      side_in.vec[i]   = l_vec[i];
      side_in.a_mag[i] = l_mag[i];
    end
    side_in.a_neg   = l_neg;
    side_in.vec_ovf = |l_ovf;
    if ((dot_sh[DW-1:W-1] == '0) || (dot_sh[DW-1:W-1] == '1)) begin
      side_in.dot = dot_sh[W-1:0];
    end else begin
      side_in.dot     = dot_sh[DW-1] ? MINV : MAXV;
      side_in.dot_ovf = 1'b1;
    end
    if (sq_sh[QSW-1:W-1] == '0) begin
      side_in.sq = sq_sh[W-1:0];
    end else begin
      side_in.sq     = MAXV;
      side_in.sq_ovf = 1'b1;
    end
    side_in.s_zero = (s_sum == '0);
  end

  vec3_isqrt #(.W(W)) u_isqrt (
    .clk      (clk),
    .ce       (ce),
    .radicand (s_sum),
    .root     (root)
  );

  always_comb begin
    side_mid = side_a[W-1];
    side_mid.len_ovf = root[W-1];
    side_mid.len     = root[W-1] ? MAXV : root;
  end

  assign last = side_b[F];

  // normalize: apply sign to the quotient and saturate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_sgn[i] = last.a_neg[i] ? -QW'(quo[i]) : QW'(quo[i]);
      if ((q_sgn[i][QW-1:W-1] == '0) || (q_sgn[i][QW-1:W-1] == '1)) begin
        nq[i]     = q_sgn[i][W-1:0];
        nq_ovf[i] = 1'b0;
      end else begin
        nq[i]     = q_sgn[i][QW-1] ? MINV : MAXV;
        nq_ovf[i] = 1'b1;
      end
    end
  end

  always_comb begin
    vec_next    = '0;
    scalar_next = '0;
    ovf_next    = 1'b0;
    zl_next     = 1'b0;
    unique case (last.cmd) inside
      CMD_ADD, CMD_SUB, CMD_CROSS: begin
        vec_next = last.vec;
        ovf_next = last.vec_ovf;
      end
      CMD_DOT: begin
        scalar_next = last.dot;
        ovf_next    = last.dot_ovf;
      end
      CMD_LSQ: begin
        scalar_next = last.sq;
        ovf_next    = last.sq_ovf;
      end
      CMD_LEN: begin
        scalar_next = last.len;
        ovf_next    = last.len_ovf;
      end
      CMD_NORM: begin
        if (last.s_zero) begin
          zl_next = 1'b1;
        end else begin
          vec_next = nq;
          ovf_next = |nq_ovf;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.valid <= 1'b0;
      ctl2.valid <= 1'b0;
      for (int i = 0; i < W; i++) begin
        side_a[i].valid <= 1'b0;
      end
      for (int i = 0; i <= F; i++) begin
        side_b[i].valid <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (ce) begin
      ctl1.valid <= in_valid;
      ctl1.cmd   <= command;
      ctl2       <= ctl1;
      side_a[0]  <= side_in;
      for (int i = 1; i < W; i++) begin
        side_a[i] <= side_a[i-1];
      end
      side_b[0] <= side_mid;
      for (int i = 1; i <= F; i++) begin
        side_b[i] <= side_b[i-1];
      end
      out_valid   <= last.valid;
      out_vec     <= vec_next;
      scalar      <= scalar_next;
      overflow    <= ovf_next;
      zero_length <= zl_next;
    end
  end

  assign rx = out_vec[0];
  assign ry = out_vec[1];
  assign rz = out_vec[2];

  // a zero vector under normalize leaves every value zero and no saturation
  a_zero_len_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_length |->
      rx == '0 && ry == '0 && rz == '0 && scalar == '0 && !overflow)
    else $error("zero_length item carries nonzero values");

  // scalar and vector results never mix
  a_scalar_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && scalar != '0 |-> rx == '0 && ry == '0 && rz == '0 && !zero_length)
    else $error("scalar result with vector or flag set");

  // unit vector components cannot exceed one
  a_norm_bound: assert property (@(posedge clk) disable iff (rst)
    last.valid && last.cmd == CMD_NORM && !last.s_zero |->
      quo[0] <= QMAX && quo[1] <= QMAX && quo[2] <= QMAX)
    else $error("normalize quotient above one");

endmodule

`default_nettype wire

### design/vec3_lane.sv
// vec3_lane: one component lane, products in the first stage, add/sub and
// cross term with saturation in the second. Depends on vec3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vec3_lane #(
  parameter int W = vec3_pkg::WORD_BITS_DEF,
  parameter int F = vec3_pkg::FRAC_BITS_DEF
) (
  input  wire                   clk,
  input  wire                   ce,
  input  wire vec3_pkg::cmd_t   cmd,
  input  wire signed [W-1:0]    a_self,
  input  wire signed [W-1:0]    b_self,
  input  wire signed [W-1:0]    a_next,
  input  wire signed [W-1:0]    b_next,
  input  wire signed [W-1:0]    a_far,
  input  wire signed [W-1:0]    b_far,
  output logic signed [W-1:0]   vec,
  output logic                  vec_ovf,
  output logic signed [2*W-1:0] p_aa,
  output logic signed [2*W-1:0] p_ab,
  output logic [W-1:0]          a_mag,
  output logic                  a_neg
);
  import vec3_pkg::*;

  localparam int PW = 2 * W;
  localparam int CW = PW + 1;
  localparam int SW = CW - F;
  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  logic signed [PW-1:0] p_aa1, p_ab1, p_c1, p_c2;
  logic signed [W:0]    sum, diff;
  logic signed [W-1:0]  a_d;
  cmd_t                 cmd_d;

  logic signed [CW-1:0] cross_w;
  logic signed [SW-1:0] cross_sh;
  logic signed [W:0]    as_sel;
  logic signed [W-1:0]  vec_next;
  logic                 vec_ovf_next;

  always_ff @(posedge clk) begin
    if (ce) begin
      p_aa1 <= PW'(a_self) * PW'(a_self);
      p_ab1 <= PW'(a_self) * PW'(b_self);
      p_c1  <= PW'(a_next) * PW'(b_far);
      p_c2  <= PW'(b_next) * PW'(a_far);
      sum   <= (W+1)'(a_self) + (W+1)'(b_self);
      diff  <= (W+1)'(a_self) - (W+1)'(b_self);
      a_d   <= a_self;
      cmd_d <= cmd;
    end
  end

  always_comb begin
    cross_w      = CW'(p_c1) - CW'(p_c2);
    cross_sh     = SW'(cross_w >>> F);
    as_sel       = (cmd_d == CMD_SUB) ? diff : sum;
    vec_next     = '0;
    vec_ovf_next = 1'b0;
    case (cmd_d) inside
      CMD_ADD, CMD_SUB: begin
        if (as_sel[W] == as_sel[W-1]) begin
          vec_next = as_sel[W-1:0];
        end else begin
          vec_next     = as_sel[W] ? MINV : MAXV;
          vec_ovf_next = 1'b1;
        end
      end
      CMD_CROSS: begin
        if ((cross_sh[SW-1:W-1] == '0) || (cross_sh[SW-1:W-1] == '1)) begin
          vec_next = cross_sh[W-1:0];
        end else begin
          vec_next     = cross_sh[SW-1] ? MINV : MAXV;
          vec_ovf_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      vec     <= vec_next;
      vec_ovf <= vec_ovf_next;
      p_aa    <= p_aa1;
      p_ab    <= p_ab1;
      a_mag   <= a_d[W-1] ? $unsigned(-a_d) : $unsigned(a_d);
      a_neg   <= a_d[W-1];
    end
  end

endmodule

`default_nettype wire

### design/vec3_isqrt.sv
// vec3_isqrt: pipelined integer square root, one result bit per stage.
// Pure datapath; the width default comes from vec3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vec3_isqrt #(
  parameter int W = vec3_pkg::WORD_BITS_DEF
) (
  input  wire             clk,
  input  wire             ce,
  input  wire [2*W-1:0]   radicand,
  output logic [W-1:0]    root
);

  localparam int RW = 2 * W + 1;

  logic [RW-1:0] rem_q  [W];
  logic [W-1:0]  root_q [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    localparam int B = W - 1 - k;
    logic [RW-1:0] rem_in, trial;
    logic [W-1:0]  root_in;

    if (k == 0) begin : g_first
      assign rem_in  = RW'(radicand);
      assign root_in = '0;
    end else begin : g_rest
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // (2r + 2^b) * 2^b, with r holding only bits above b
    assign trial = (RW'(root_in) << (B + 1)) | (RW'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (ce) begin
        if (rem_in >= trial) begin
          rem_q[k]  <= rem_in - trial;
          root_q[k] <= root_in | (W'(1) << B);
        end else begin
          rem_q[k]  <= rem_in;
          root_q[k] <= root_in;
        end
      end
    end
  end

  assign root = root_q[W-1];

endmodule

`default_nettype wire

### design/vec3_div.sv
// vec3_div: pipelined restoring divider, (mag << F) / den, one quotient
// bit per stage. Pure datapath; width defaults come from vec3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vec3_div #(
  parameter int W = vec3_pkg::WORD_BITS_DEF,
  parameter int F = vec3_pkg::FRAC_BITS_DEF
) (
  input  wire          clk,
  input  wire          ce,
  input  wire [W-1:0]  mag,
  input  wire [W-1:0]  den,
  output logic [F:0]   quo
);

  localparam int NW = W + F;
  localparam int N  = F + 1;

  logic [NW-1:0] rem_q [N];
  logic [W-1:0]  den_q [N];
  logic [F:0]    quo_q [N];

  for (genvar j = 0; j < N; j++) begin : g_stage
    localparam int K = F - j;
    logic [NW-1:0] rem_in, trial;
    logic [W-1:0]  den_in;
    logic [F:0]    quo_in;

    if (j == 0) begin : g_first
      assign rem_in = NW'(mag) << F;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_rest
      assign rem_in = rem_q[j-1];
      assign den_in = den_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    assign trial = NW'(den_in) << K;

    always_ff @(posedge clk) begin
      if (ce) begin
        den_q[j] <= den_in;
        if (rem_in >= trial) begin
          rem_q[j] <= rem_in - trial;
          quo_q[j] <= quo_in | ((F+1)'(1) << K);
        end else begin
          rem_q[j] <= rem_in;
          quo_q[j] <= quo_in;
        end
      end
    end
  end

  assign quo = quo_q[N-1];

endmodule

`default_nettype wire
